>>> hdl/mcr_pkg.sv
// Package for the midpoint circle rasterizer.
// Holds the shared constants, register indexes and default widths.
// No dependencies; every other file of the block imports it.
package mcr_pkg;

  // Default coordinate width of the centre and radius fields.
  localparam int COORD_BITS_DEF = 10;

  // Width and reset value of the image size registers.
  localparam int IMG_BITS = 11;
  localparam logic [IMG_BITS-1:0] IMG_SIZE_RESET = 11'd300;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // Item opcodes.
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Number of runs the queue between front and back can hold.
  localparam int QUEUE_DEPTH = 2;

  // Pixels emitted for one octant point.
  localparam int RUN_LEN = 8;

endpackage

>>> hdl/mcr_front.sv
// Front end of the circle rasterizer: accepts items and walks the octant.
// Holds the circle state and issues one run descriptor per emitting item.
// Depends on mcr_pkg.
module mcr_front
  import mcr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic                  q_full,
  input  logic                  in_opcode,
  input  logic [COORD_BITS-1:0] in_center_x,
  input  logic [COORD_BITS-1:0] in_center_y,
  input  logic [COORD_BITS-1:0] in_radius,
  output logic                  q_push,
  output logic [COORD_BITS-1:0] d_cx,
  output logic [COORD_BITS-1:0] d_cy,
  output logic [COORD_BITS:0]   d_x,
  output logic [COORD_BITS:0]   d_y,
  output logic                  d_done
);

  localparam int OCT_W = COORD_BITS + 1;
  localparam int DEC_W = COORD_BITS + 4;
  localparam int EXT_W = DEC_W - OCT_W;

  localparam logic [DEC_W-1:0] DEC_THREE = DEC_W'(3);
  localparam logic [DEC_W-1:0] DEC_SIX   = DEC_W'(6);
  localparam logic [DEC_W-1:0] DEC_TEN   = DEC_W'(10);

  logic                  active_r, active_nxt;
  logic [COORD_BITS-1:0] cx_r, cx_nxt;
  logic [COORD_BITS-1:0] cy_r, cy_nxt;
  logic [OCT_W-1:0]      x_r, x_nxt;
  logic [OCT_W-1:0]      y_r, y_nxt;
  logic [DEC_W-1:0]      dec_r, dec_nxt;

  logic             accept;
  logic             dec_pos;
  logic [OCT_W-1:0] x_inc;
  logic [OCT_W-1:0] y_dec;
  logic [DEC_W-1:0] diff_ext;
  logic [DEC_W-1:0] x_ext;
  logic             step_done;

  assign accept = in_push && !q_full;

  // Octant step arithmetic, all modulo the state widths.
  assign dec_pos   = !dec_r[DEC_W-1] && (|dec_r);
  assign x_inc     = x_r + OCT_W'(1);
  assign y_dec     = dec_pos ? (y_r - OCT_W'(1)) : y_r;
  assign x_ext     = {{EXT_W{x_inc[OCT_W-1]}}, x_inc};
  assign diff_ext  = x_ext - {{EXT_W{y_dec[OCT_W-1]}}, y_dec};
  assign step_done = $signed(y_dec) < $signed(x_inc);

  // Next state and run descriptor for the accepted item.
  always_comb begin
    active_nxt = active_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    dec_nxt    = dec_r;
    q_push     = 1'b0;
    d_done     = 1'b0;
    if (accept) begin
      if (in_opcode == OP_START) begin
        active_nxt = 1'b1;
        cx_nxt     = in_center_x;
        cy_nxt     = in_center_y;
        x_nxt      = '0;
        y_nxt      = OCT_W'(in_radius);
        dec_nxt    = DEC_THREE - (DEC_W'(in_radius) << 1);
        q_push     = 1'b1;
      end else if (active_r) begin
        x_nxt      = x_inc;
        y_nxt      = y_dec;
        if (dec_pos) begin
          dec_nxt = dec_r + (diff_ext << 2) + DEC_TEN;
        end else begin
          dec_nxt = dec_r + (x_ext << 2) + DEC_SIX;
        end
        active_nxt = !step_done;
        d_done     = step_done;
        q_push     = 1'b1;
      end
    end
  end

  // The descriptor carries the point after the update.
  assign d_cx = cx_nxt;
  assign d_cy = cy_nxt;
  assign d_x  = x_nxt;
  assign d_y  = y_nxt;

  // Circle state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cx_r     <= '0;
      cy_r     <= '0;
      x_r      <= '0;
      y_r      <= '0;
      dec_r    <= '0;
    end else begin
      active_r <= active_nxt;
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      dec_r    <= dec_nxt;
    end
  end

endmodule

>>> hdl/mcr_queue.sv
// Short run queue between the front end and the pixel back end.
// Holds run descriptors in a small register array with a head read port.
// Depends on mcr_pkg.
module mcr_queue
  import mcr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [COORD_BITS-1:0] w_cx,
  input  logic [COORD_BITS-1:0] w_cy,
  input  logic [COORD_BITS:0]   w_x,
  input  logic [COORD_BITS:0]   w_y,
  input  logic                  w_done,
  input  logic                  pop,
  output logic                  full,
  output logic                  valid,
  output logic [COORD_BITS-1:0] h_cx,
  output logic [COORD_BITS-1:0] h_cy,
  output logic [COORD_BITS:0]   h_x,
  output logic [COORD_BITS:0]   h_y,
  output logic                  h_done
);

  localparam int OCT_W  = COORD_BITS + 1;
  localparam int DESC_W = 2 * COORD_BITS + 2 * OCT_W + 1;
  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [DESC_W-1:0] mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;
  logic [DESC_W-1:0] head;

  assign full    = (cnt_r == CNT_FULL);
  assign valid   = (cnt_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Descriptor storage; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= {w_cx, w_cy, w_x, w_y, w_done};
    end
  end

  assign head = mem_r[rd_ptr_r];
  assign {h_cx, h_cy, h_x, h_y, h_done} = head;

endmodule

>>> hdl/mcr_back.sv
// Back end of the circle rasterizer: expands one run into eight pixels.
// Steps a pixel counter over the queue head and fills the output register.
// Depends on mcr_pkg.
module mcr_back
  import mcr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  logic [COORD_BITS-1:0]        h_cx,
  input  logic [COORD_BITS-1:0]        h_cy,
  input  logic [COORD_BITS:0]          h_x,
  input  logic [COORD_BITS:0]          h_y,
  input  logic                         h_done,
  output logic                         q_pop,
  input  logic [IMG_BITS-1:0]          image_width,
  input  logic [IMG_BITS-1:0]          image_height,
  input  logic                         out_pop,
  output logic                         out_empty,
  output logic signed [COORD_BITS+1:0] out_pixel_x,
  output logic signed [COORD_BITS+1:0] out_pixel_y,
  output logic                         out_visible,
  output logic                         out_last_of_step,
  output logic                         out_circle_done
);

  localparam int OCT_W = COORD_BITS + 1;
  localparam int PIX_W = COORD_BITS + 2;
  localparam int CMP_W = (PIX_W > IMG_BITS) ? PIX_W : IMG_BITS;
  localparam int K_W   = $clog2(RUN_LEN);
  localparam logic [K_W-1:0] K_LAST = K_W'(RUN_LEN - 1);

  logic [K_W-1:0]   k_r, k_nxt;
  logic             valid_r, valid_nxt;
  logic [PIX_W-1:0] px_r, py_r;
  logic             vis_r, last_r, done_r;

  logic             load;
  logic             slot_free;
  logic [OCT_W-1:0] a_off, b_off;
  logic [PIX_W-1:0] a_ext, b_ext;
  logic [PIX_W-1:0] px, py;
  logic             vis;
  logic             last_pix;

  // Pixel order: k[2] swaps x and y, k[0] negates the column offset,
  // k[1] negates the row offset.
  assign a_off = k_r[2] ? h_y : h_x;
  assign b_off = k_r[2] ? h_x : h_y;
  assign a_ext = {a_off[OCT_W-1], a_off};
  assign b_ext = {b_off[OCT_W-1], b_off};
  assign px    = PIX_W'(h_cx) + (k_r[0] ? (PIX_W'(0) - a_ext) : a_ext);
  assign py    = PIX_W'(h_cy) + (k_r[1] ? (PIX_W'(0) - b_ext) : b_ext);

  // Visibility against the image bounds.
  assign vis = !px[PIX_W-1] && !py[PIX_W-1] &&
               (CMP_W'(px) < CMP_W'(image_width)) &&
               (CMP_W'(py) < CMP_W'(image_height));

  assign last_pix  = (k_r == K_LAST);
  assign slot_free = !valid_r || out_pop;
  assign load      = q_valid && slot_free;
  assign q_pop     = load && last_pix;

  // Pixel counter and output register valid.
  always_comb begin
    k_nxt     = k_r;
    valid_nxt = valid_r;
    if (slot_free) begin
      valid_nxt = q_valid;
    end
    if (load) begin
      k_nxt = last_pix ? '0 : k_r + K_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= '0;
      valid_r <= 1'b0;
    end else begin
      k_r     <= k_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      px_r   <= px;
      py_r   <= py;
      vis_r  <= vis;
      last_r <= last_pix;
      done_r <= last_pix && h_done;
    end
  end

  assign out_empty        = !valid_r;
  assign out_pixel_x      = $signed(px_r);
  assign out_pixel_y      = $signed(py_r);
  assign out_visible      = vis_r;
  assign out_last_of_step = last_r;
  assign out_circle_done  = done_r;

endmodule

>>> hdl/midpoint_circle_rasterizer_top.sv
// Top level of the midpoint circle rasterizer.
// Holds the image size registers and joins front end, run queue and back end.
// Depends on mcr_pkg, mcr_front, mcr_queue and mcr_back.
//
//   Channel   Handshake             Beat carries
//   in_       push / full           opcode, center_x, center_y, radius
//   out_      empty / pop           pixel_x, pixel_y, visible, last_of_step,
//                                   circle_done
//   cfg_      valid / ready         index, wdata (image width or height)
//
// A start item, or a step item while a circle is active, yields eight pixels,
// one per cycle while out_pop is held high, so the sustained rate is set by
// the one-pixel-per-cycle result channel. The front end updates the octant in
// the cycle it takes an item; with the back end idle the run passes through
// the run queue and then the output register before its first pixel is on the
// out_ ports. The run queue holds the run being expanded and one waiting run,
// and in_full is high while both are held. A step item with no active circle
// is taken and yields nothing. Reset is synchronous and active low; it clears
// the circle state, the queue and the output register's valid flag and sets
// both image sizes to 300. cfg_ready is always high.
module midpoint_circle_rasterizer_top
  import mcr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic                         in_opcode,
  input  logic [COORD_BITS-1:0]        in_center_x,
  input  logic [COORD_BITS-1:0]        in_center_y,
  input  logic [COORD_BITS-1:0]        in_radius,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic signed [COORD_BITS+1:0] out_pixel_x,
  output logic signed [COORD_BITS+1:0] out_pixel_y,
  output logic                         out_visible,
  output logic                         out_last_of_step,
  output logic                         out_circle_done,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [IMG_BITS-1:0]          cfg_wdata
);

  logic [IMG_BITS-1:0] image_width_r, image_width_nxt;
  logic [IMG_BITS-1:0] image_height_r, image_height_nxt;

  logic                  q_push, q_pop, q_full, q_valid;
  logic [COORD_BITS-1:0] d_cx, d_cy, h_cx, h_cy;
  logic [COORD_BITS:0]   d_x, d_y, h_x, h_y;
  logic                  d_done, h_done;

  // Configuration writes; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_comb begin
    image_width_nxt  = image_width_r;
    image_height_nxt = image_height_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width_nxt  = cfg_wdata;
        REG_IMAGE_HEIGHT: image_height_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= IMG_SIZE_RESET;
      image_height_r <= IMG_SIZE_RESET;
    end else begin
      image_width_r  <= image_width_nxt;
      image_height_r <= image_height_nxt;
    end
  end

  assign in_full = q_full;

  // Front end: takes items and walks the octant.
  mcr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .q_full     (q_full),
    .in_opcode  (in_opcode),
    .in_center_x(in_center_x),
    .in_center_y(in_center_y),
    .in_radius  (in_radius),
    .q_push     (q_push),
    .d_cx       (d_cx),
    .d_cy       (d_cy),
    .d_x        (d_x),
    .d_y        (d_y),
    .d_done     (d_done)
  );

  // Run queue between the two halves.
  mcr_queue #(
    .COORD_BITS(COORD_BITS)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .w_cx  (d_cx),
    .w_cy  (d_cy),
    .w_x   (d_x),
    .w_y   (d_y),
    .w_done(d_done),
    .pop   (q_pop),
    .full  (q_full),
    .valid (q_valid),
    .h_cx  (h_cx),
    .h_cy  (h_cy),
    .h_x   (h_x),
    .h_y   (h_y),
    .h_done(h_done)
  );

  // Back end: eight pixels per run.
  mcr_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .h_cx            (h_cx),
    .h_cy            (h_cy),
    .h_x             (h_x),
    .h_y             (h_y),
    .h_done          (h_done),
    .q_pop           (q_pop),
    .image_width     (image_width_r),
    .image_height    (image_height_r),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_visible     (out_visible),
    .out_last_of_step(out_last_of_step),
    .out_circle_done (out_circle_done)
  );

endmodule

>>> dv/tb_top.sv
// Testbench for midpoint_circle_rasterizer_top: random and directed start and step items.
// Each pixel is checked against an in-bench circle predictor held in a scoreboard class.
// Depends on mcr_pkg and on the RTL of the block.
`timescale 1ns / 100ps

module tb_top
  import mcr_pkg::*;
();

  localparam int COORD_W = COORD_BITS_DEF;
  localparam int OCT_W = COORD_W + 1;
  localparam int DEC_W = COORD_W + 4;
  localparam int PIX_W = COORD_W + 2;
  localparam int IDLE_PCT = 34;
  localparam int SETTLE_CYCLES = 32;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 100;
  localparam int PHASE_ITEMS = 34;
  localparam logic [CFG_IDX_BITS-1:0] UNUSED_IDX_A = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] UNUSED_IDX_B = 2'd3;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [IMG_BITS-1:0] img_size_t;

  typedef struct {
    logic signed [PIX_W-1:0] px;
    logic signed [PIX_W-1:0] py;
    logic visible;
    logic last_of_step;
    logic circle_done;
  } pixel_t;

  // Scoreboard: tracks the circle walk and the image size, and holds the
  // pixels still owed by the block in the order they must arrive.
  class circle_scoreboard;
    img_size_t img_w;
    img_size_t img_h;
    bit active;
    int centre_x;
    int centre_y;
    logic signed [OCT_W-1:0] oct_x;
    logic signed [OCT_W-1:0] oct_y;
    logic signed [DEC_W-1:0] decision;
    pixel_t expected_pixels[$];
    int errors;

    function new();
      img_w = IMG_SIZE_RESET;
      img_h = IMG_SIZE_RESET;
      active = 1'b0;
      centre_x = 0;
      centre_y = 0;
      oct_x = '0;
      oct_y = '0;
      decision = '0;
      errors = 0;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    // Writes to indexes beyond the two size registers have no effect.
    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, img_size_t val);
      if (idx == REG_IMAGE_WIDTH) img_w = val;
      else if (idx == REG_IMAGE_HEIGHT) img_h = val;
    endfunction

    function void add_pixel(int px, int py, bit last, bit done);
      pixel_t p;
      p.px = PIX_W'(px);
      p.py = PIX_W'(py);
      p.visible = px >= 0 && py >= 0 && px < int'(img_w) && py < int'(img_h);
      p.last_of_step = last;
      p.circle_done = last && done;
      expected_pixels.push_back(p);
    endfunction

    // The eight symmetric pixels of the current octant point.
    function void plot_eight(bit done);
      int x;
      int y;
      x = oct_x;
      y = oct_y;
      add_pixel(centre_x + x, centre_y + y, 1'b0, done);
      add_pixel(centre_x - x, centre_y + y, 1'b0, done);
      add_pixel(centre_x + x, centre_y - y, 1'b0, done);
      add_pixel(centre_x - x, centre_y - y, 1'b0, done);
      add_pixel(centre_x + y, centre_y + x, 1'b0, done);
      add_pixel(centre_x - y, centre_y + x, 1'b0, done);
      add_pixel(centre_x + y, centre_y - x, 1'b0, done);
      add_pixel(centre_x - y, centre_y - x, 1'b1, done);
    endfunction

    // Advances the predicted circle by one accepted input beat.
    function void note_item(logic op, coord_t cx_in, coord_t cy_in, coord_t r_in);
      bit finished;
      if (op == OP_START) begin
        centre_x = cx_in;
        centre_y = cy_in;
        oct_x = '0;
        oct_y = OCT_W'(int'(r_in));
        decision = DEC_W'(3 - 2 * int'(r_in));
        active = 1'b1;
        plot_eight(1'b0);
      end else if (active) begin
        oct_x = OCT_W'(oct_x + 1);
        if (decision > 0) begin
          oct_y = OCT_W'(oct_y - 1);
          decision = DEC_W'(decision + 4 * (oct_x - oct_y) + 10);
        end else begin
          decision = DEC_W'(decision + 4 * oct_x + 6);
        end
        finished = oct_y < oct_x;
        if (finished) active = 1'b0;
        plot_eight(finished);
      end
    endfunction

    task report_mismatch(string text);
      if (errors < MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, text);
      errors++;
    endtask

    // Compares one accepted output beat with the oldest owed pixel.
    task check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("pixel (%0d, %0d) with none expected", got.px, got.py));
        return;
      end
      want = expected_pixels.pop_front();
      if (got.px !== want.px)
        report_mismatch($sformatf("pixel_x expected %0d, got %0d", want.px, got.px));
      if (got.py !== want.py)
        report_mismatch($sformatf("pixel_y expected %0d, got %0d", want.py, got.py));
      if (got.visible !== want.visible)
        report_mismatch($sformatf("visible expected %0b, got %0b", want.visible, got.visible));
      if (got.last_of_step !== want.last_of_step)
        report_mismatch($sformatf("last_of_step expected %0b, got %0b",
                                  want.last_of_step, got.last_of_step));
      if (got.circle_done !== want.circle_done)
        report_mismatch($sformatf("circle_done expected %0b, got %0b",
                                  want.circle_done, got.circle_done));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic in_opcode = OP_START;
  coord_t in_center_x = '0;
  coord_t in_center_y = '0;
  coord_t in_radius = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic signed [PIX_W-1:0] out_pixel_x;
  logic signed [PIX_W-1:0] out_pixel_y;
  logic out_visible;
  logic out_last_of_step;
  logic out_circle_done;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_IMAGE_WIDTH;
  img_size_t cfg_wdata = '0;

  // Random idling on both sides is allowed while this is set.
  bit idle_on = 1'b1;
  circle_scoreboard sb;

  midpoint_circle_rasterizer_top #(.COORD_BITS(COORD_W)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_opcode(in_opcode),
    .in_center_x(in_center_x),
    .in_center_y(in_center_y),
    .in_radius(in_radius),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_pixel_x(out_pixel_x),
    .out_pixel_y(out_pixel_y),
    .out_visible(out_visible),
    .out_last_of_step(out_last_of_step),
    .out_circle_done(out_circle_done),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // Output side: check each accepted beat, then choose whether to stall.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty)
      sb.check_pixel(pixel_t'{out_pixel_x, out_pixel_y, out_visible,
                              out_last_of_step, out_circle_done});
    out_pop <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
  end

  // Ends the run when no beat moves on any channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  // Offers one input beat, idling first at random, and waits until it is taken.
  task automatic send_item(logic op, coord_t cx, coord_t cy, coord_t r);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_opcode <= op;
    in_center_x <= cx;
    in_center_y <= cy;
    in_radius <= r;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_item(op, cx, cy, r);
  endtask

  task automatic send_step();
    send_item(OP_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
  endtask

  // Stops the sender until every owed pixel has been received.
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, img_size_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // Size registers change only once the block is idle; a step taken with no
  // circle active gives no pixel, so a settling pause follows the drain.
  task automatic reconfigure(img_size_t w, img_size_t h, bit poke_unused);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_IMAGE_WIDTH, w);
    if (poke_unused) begin
      write_reg(UNUSED_IDX_A, img_size_t'($urandom));
      write_reg(UNUSED_IDX_B, img_size_t'($urandom));
    end
    write_reg(REG_IMAGE_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  // Mostly small radii so that circles close; a few large ones for the upper bits.
  function automatic coord_t pick_radius();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return coord_t'($urandom_range(0, 24));
    if (roll < 85) return coord_t'($urandom_range(25, 80));
    if (roll < 97) return coord_t'($urandom_range(0, 1023));
    return coord_t'(1023);
  endfunction

  // Half of the centres fall inside the image so that visibility varies.
  function automatic coord_t pick_centre(img_size_t span);
    if ($urandom_range(1) == 0 || span > 1023) return coord_t'($urandom_range(0, 1023));
    return coord_t'($urandom_range(0, span));
  endfunction

  // Mostly whole circles walked to the end, with restarts and idle steps mixed in.
  task automatic run_phase(int n_items, bit pause_midway);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      if (pause_midway && sent == n_items / 2) drain();
      if (!sb.active) begin
        if ($urandom_range(9) == 0) begin
          send_step();
        end else begin
          send_item(OP_START, pick_centre(sb.img_w), pick_centre(sb.img_h), pick_radius());
          sent++;
        end
      end else if ($urandom_range(99) < 8) begin
        send_item(OP_START, pick_centre(sb.img_w), pick_centre(sb.img_h), pick_radius());
        sent++;
      end else begin
        send_step();
        sent++;
      end
    end
  endtask

  initial begin : main
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: idle steps, zero radius, extreme fields, restart while active.
    reconfigure(11'd1024, 11'd1024, 1'b0);
    send_item(OP_STEP, coord_t'(1023), coord_t'(1023), coord_t'(1023));
    send_item(OP_START, coord_t'(512), coord_t'(512), coord_t'(10));
    repeat (3) send_step();
    send_item(OP_START, coord_t'(0), coord_t'(0), coord_t'(0));
    send_step();
    send_item(OP_STEP, coord_t'(0), coord_t'(0), coord_t'(0));
    send_item(OP_START, coord_t'(1023), coord_t'(1023), coord_t'(1023));
    send_step();
    send_item(OP_START, coord_t'(0), coord_t'(0), coord_t'(1023));
    send_step();
    send_item(OP_START, coord_t'(0), coord_t'(1023), coord_t'(1));
    send_step();
    send_item(OP_START, coord_t'(1023), coord_t'(0), coord_t'(2));
    repeat (3) send_step();

    // Zero image size hides every pixel.
    reconfigure(11'd0, 11'd0, 1'b1);
    send_item(OP_START, coord_t'(5), coord_t'(5), coord_t'(3));
    repeat (2) send_step();

    reconfigure(11'd1, 11'd1, 1'b0);
    send_item(OP_START, coord_t'(0), coord_t'(0), coord_t'(0));
    send_step();

    // Random phases under several image sizes; the second runs with no idling.
    reconfigure(IMG_SIZE_RESET, IMG_SIZE_RESET, 1'b1);
    run_phase(PHASE_ITEMS, 1'b0);
    reconfigure(img_size_t'($urandom_range(1, 1024)), img_size_t'($urandom_range(1, 1024)),
                1'b0);
    idle_on = 1'b0;
    run_phase(PHASE_ITEMS, 1'b0);
    idle_on = 1'b1;
    reconfigure(11'd2047, 11'd1, 1'b0);
    run_phase(PHASE_ITEMS, 1'b0);
    reconfigure(11'd1024, img_size_t'($urandom_range(0, 2047)), 1'b1);
    run_phase(PHASE_ITEMS, 1'b1);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> midpoint_circle_rasterizer_top.f
hdl/mcr_pkg.sv
hdl/mcr_front.sv
hdl/mcr_queue.sv
hdl/mcr_back.sv
hdl/midpoint_circle_rasterizer_top.sv
dv/tb_top.sv
